// ===== hdl/clwc_pkg.sv =====
package clwc_pkg;

   // Default sizing of the node pool
   localparam int CAPACITY_DEFAULT   = 256;
   localparam int VALUE_BITS_DEFAULT = 32;

   // Fixed field widths of the request and response channels
   localparam int DATA_BITS = 32;
   localparam int STEP_BITS = 16;
   localparam int MAG_BITS  = STEP_BITS + 1;
   localparam int CMD_BITS  = 2;
   localparam int STAT_BITS = 2;

   // Command codes
   localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_ROTATE = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_QUERY  = 2'd3;

   // Response status codes
   localparam logic [STAT_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_BITS-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STAT_BITS-1:0] STATUS_FULL  = 2'd2;

endpackage

// ===== hdl/clwc_ram.sv =====
module clwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; a read of the address being written sees old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/clwc_mod.sv =====
module clwc_mod #(
   parameter int DIVIDEND_BITS = 17,
   parameter int DIVISOR_BITS  = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVISOR_BITS-1:0]  remainder
);

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_BITS-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_BITS-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS:0]    trial;

   // Shift in one dividend bit and subtract the divisor where it fits
   assign trial = {rem_ff, dvd_ff[DIVIDEND_BITS-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(DIVIDEND_BITS - 1);
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DIVISOR_BITS'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[DIVISOR_BITS-1:0];
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder unit restarted while busy");

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < dvs_ff)
      else $error("remainder not below divisor");

   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("done without a finished division");

endmodule

// ===== hdl/circular_list_with_cursor_top.sv =====
// Circular doubly linked list with a cursor over a pool of CAPACITY nodes. Each request
// carries a command (insert after cursor, delete cursor, rotate, query) and yields exactly
// one response with the data, the element count after the command and a status. All nodes
// live in one single-port-write RAM with a registered read, one row per node
// holding value, next and prev link; a free node keeps its free-list link in the next field,
// and nodes never yet handed out are tracked by a fill count, so no clearing pass is needed
// after reset. Every read-modify-write goes through that RAM one access per cycle. A rotate
// takes the bit-serial remainder of the step count by the element count and then walks that
// remainder one link per cycle. While a stalled response holds the output register, the
// next command waits in its response state. The next request is taken once the current one
// has reached the response register.
module circular_list_with_cursor_top #(
   parameter int CAPACITY   = clwc_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_BITS = clwc_pkg::VALUE_BITS_DEFAULT,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [clwc_pkg::CMD_BITS-1:0]          req_cmd,
   input  logic signed [clwc_pkg::DATA_BITS-1:0]  req_value,
   input  logic signed [clwc_pkg::STEP_BITS-1:0]  req_rotate_steps,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [clwc_pkg::DATA_BITS-1:0]  rsp_data,
   output logic [CW-1:0]                          rsp_count,
   output logic [clwc_pkg::STAT_BITS-1:0]         rsp_status
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int RW   = VALUE_BITS + 2 * AW;
   localparam int V_LO = 2 * AW;
   localparam int N_LO = AW;
   localparam int DB   = clwc_pkg::DATA_BITS;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DISPATCH = 4'd1;
   localparam logic [3:0] ST_INS_FL   = 4'd2;
   localparam logic [3:0] ST_INS_N    = 4'd3;
   localparam logic [3:0] ST_INS_WC   = 4'd4;
   localparam logic [3:0] ST_INS_WN   = 4'd5;
   localparam logic [3:0] ST_DEL_PV   = 4'd6;
   localparam logic [3:0] ST_DEL_N    = 4'd7;
   localparam logic [3:0] ST_DEL_WN   = 4'd8;
   localparam logic [3:0] ST_DEL_FREE = 4'd9;
   localparam logic [3:0] ST_ROT_DIV  = 4'd10;
   localparam logic [3:0] ST_ROT_WALK = 4'd11;
   localparam logic [3:0] ST_RESP     = 4'd12;

   // Sign-extend a stored value to the data field
   function automatic logic [DB-1:0] ext_val(input logic [VALUE_BITS-1:0] v);
      logic [DB-1:0] r;
      for (int i = 0; i < DB; i++) begin
         if (i < VALUE_BITS) r[i] = v[i];
         else                r[i] = v[VALUE_BITS-1];
      end
      return r;
   endfunction

   // Keep the low VALUE_BITS of a sign-extended request value
   function automatic logic [VALUE_BITS-1:0] fit_val(input logic [DB-1:0] d);
      logic [VALUE_BITS-1:0] r;
      for (int i = 0; i < VALUE_BITS; i++) begin
         if (i < DB) r[i] = d[i];
         else        r[i] = d[DB-1];
      end
      return r;
   endfunction

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
      return (p == AW'(CAPACITY - 1)) ? '0 : p + AW'(1);
   endfunction

   logic [3:0]                        state_ff, state_in;
   logic [clwc_pkg::CMD_BITS-1:0]     cmd_ff, cmd_in;
   logic [VALUE_BITS-1:0]             value_ff, value_in;
   logic [clwc_pkg::STEP_BITS-1:0]    steps_ff, steps_in;
   logic [AW-1:0]                     cursor_ff, cursor_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [AW-1:0]                     free_head_ff, free_head_in;
   logic [CW-1:0]                     fresh_ff, fresh_in;
   logic [AW-1:0]                     node_ff, node_in;
   logic [RW-1:0]                     crow_ff, crow_in;
   logic [RW-1:0]                     prow_ff, prow_in;
   logic [RW-1:0]                     nrow_ff, nrow_in;
   logic [CW-1:0]                     left_ff, left_in;
   logic                              first_ff, first_in;
   logic [DB-1:0]                     res_data_ff, res_data_in;
   logic [clwc_pkg::STAT_BITS-1:0]    res_status_ff, res_status_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [DB-1:0]                     rsp_data_ff, rsp_data_in;
   logic [CW-1:0]                     rsp_count_ff, rsp_count_in;
   logic [clwc_pkg::STAT_BITS-1:0]    rsp_status_ff, rsp_status_in;

   logic                              ram_we;
   logic [AW-1:0]                     ram_waddr;
   logic [RW-1:0]                     ram_wdata;
   logic [AW-1:0]                     ram_raddr;
   logic [RW-1:0]                     ram_rdata;

   logic                              req_fire;
   logic                              div_start;
   logic                              div_done;
   logic [CW-1:0]                     div_rem;
   logic [clwc_pkg::MAG_BITS-1:0]     step_mag;
   logic                              step_back;
   logic                              from_chain;
   logic [RW-1:0]                     walk_row;
   logic [AW-1:0]                     walk_next;

   logic [VALUE_BITS-1:0]             rd_val, crow_val, prow_val, nrow_val, walk_val;
   logic [AW-1:0]                     rd_prev;
   logic [AW-1:0]                     crow_next, crow_prev;
   logic [AW-1:0]                     prow_prev, nrow_next;

   // Row fields
   assign rd_val    = ram_rdata[RW-1:V_LO];
   assign rd_prev   = ram_rdata[AW-1:0];
   assign crow_val  = crow_ff[RW-1:V_LO];
   assign crow_next = crow_ff[V_LO-1:N_LO];
   assign crow_prev = crow_ff[AW-1:0];
   assign prow_val  = prow_ff[RW-1:V_LO];
   assign prow_prev = prow_ff[AW-1:0];
   assign nrow_val  = nrow_ff[RW-1:V_LO];
   assign nrow_next = nrow_ff[V_LO-1:N_LO];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Magnitude and direction of a rotation
   assign step_back = steps_ff[clwc_pkg::STEP_BITS-1];
   assign step_mag  = step_back
      ? clwc_pkg::MAG_BITS'((clwc_pkg::MAG_BITS'(1) << clwc_pkg::STEP_BITS)
                            - {1'b0, steps_ff})
      : {1'b0, steps_ff};

   // A node taken from the untouched part of the pool links on to its successor slot
   assign from_chain = (fresh_ff != CW'(CAPACITY)) && (node_ff == fresh_ff[AW-1:0]);

   // Cursor walk: first step from the held cursor row, later steps from the RAM
   assign walk_row  = first_ff ? crow_ff : ram_rdata;
   assign walk_val  = walk_row[RW-1:V_LO];
   assign walk_next = step_back ? walk_row[AW-1:0] : walk_row[V_LO-1:N_LO];

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      steps_in      = steps_ff;
      cursor_in     = cursor_ff;
      count_in      = count_ff;
      free_head_in  = free_head_ff;
      fresh_in      = fresh_ff;
      node_in       = node_ff;
      crow_in       = crow_ff;
      prow_in       = prow_ff;
      nrow_in       = nrow_ff;
      left_in       = left_ff;
      first_in      = first_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = cursor_ff;
      ram_wdata     = crow_ff;
      ram_raddr     = cursor_ff;
      div_start     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // Capture the request; the cursor row is read in the same cycle
            if (req_fire) begin
               cmd_in   = req_cmd;
               value_in = fit_val(req_value);
               steps_in = req_rotate_steps;
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            crow_in       = ram_rdata;
            res_status_in = clwc_pkg::STATUS_OK;
            unique case (cmd_ff)
               clwc_pkg::CMD_INSERT: begin
                  if (count_ff == CW'(CAPACITY)) begin
                     res_status_in = clwc_pkg::STATUS_FULL;
                     res_data_in   = ext_val(rd_val);
                     state_in      = ST_RESP;
                  end else begin
                     node_in   = free_head_ff;
                     ram_raddr = free_head_ff;
                     state_in  = ST_INS_FL;
                  end
               end
               clwc_pkg::CMD_DELETE: begin
                  if (count_ff == '0) begin
                     res_status_in = clwc_pkg::STATUS_EMPTY;
                     res_data_in   = '0;
                     state_in      = ST_RESP;
                  end else begin
                     res_data_in = ext_val(rd_val);
                     node_in     = cursor_ff;
                     if (count_ff == CW'(1)) begin
                        state_in = ST_DEL_FREE;
                     end else begin
                        ram_raddr = rd_prev;
                        state_in  = ST_DEL_PV;
                     end
                  end
               end
               clwc_pkg::CMD_ROTATE: begin
                  if (count_ff == '0) begin
                     res_data_in = '0;
                     state_in    = ST_RESP;
                  end else begin
                     div_start = 1'b1;
                     first_in  = 1'b1;
                     state_in  = ST_ROT_DIV;
                  end
               end
               clwc_pkg::CMD_QUERY: begin
                  res_data_in = (count_ff == '0) ? '0 : ext_val(rd_val);
                  state_in    = ST_RESP;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end

         ST_INS_FL: begin
            // Pop the free list
            if (from_chain) begin
               free_head_in = next_slot(node_ff);
               fresh_in     = fresh_ff + CW'(1);
            end else begin
               free_head_in = ram_rdata[V_LO-1:N_LO];
            end
            res_data_in = ext_val(value_ff);
            if (count_ff == '0) begin
               ram_we    = 1'b1;
               ram_waddr = node_ff;
               ram_wdata = {value_ff, node_ff, node_ff};
               cursor_in = node_ff;
               count_in  = count_ff + CW'(1);
               state_in  = ST_RESP;
            end else begin
               ram_raddr = crow_next;
               state_in  = ST_INS_N;
            end
         end

         ST_INS_N: begin
            // Write the new node between cursor and its successor
            nrow_in   = ram_rdata;
            ram_we    = 1'b1;
            ram_waddr = node_ff;
            ram_wdata = {value_ff, crow_next, cursor_ff};
            state_in  = ST_INS_WC;
         end

         ST_INS_WC: begin
            ram_we    = 1'b1;
            ram_waddr = cursor_ff;
            ram_wdata = {crow_val, node_ff, (crow_next == cursor_ff) ? node_ff : crow_prev};
            state_in  = ST_INS_WN;
         end

         ST_INS_WN: begin
            ram_we    = 1'b1;
            ram_waddr = crow_next;
            ram_wdata = {nrow_val, (crow_next == cursor_ff) ? node_ff : nrow_next, node_ff};
            cursor_in = node_ff;
            count_in  = count_ff + CW'(1);
            state_in  = ST_RESP;
         end

         ST_DEL_PV: begin
            prow_in   = ram_rdata;
            ram_raddr = crow_next;
            state_in  = ST_DEL_N;
         end

         ST_DEL_N: begin
            // Link the predecessor past the deleted node
            nrow_in   = ram_rdata;
            ram_we    = 1'b1;
            ram_waddr = crow_prev;
            ram_wdata = {prow_val, crow_next,
                         (crow_prev == crow_next) ? crow_prev : prow_prev};
            state_in  = ST_DEL_WN;
         end

         ST_DEL_WN: begin
            ram_we    = 1'b1;
            ram_waddr = crow_next;
            ram_wdata = {nrow_val, (crow_prev == crow_next) ? crow_next : nrow_next,
                         crow_prev};
            cursor_in = crow_next;
            state_in  = ST_DEL_FREE;
         end

         ST_DEL_FREE: begin
            // Push the deleted node onto the free list
            ram_we       = 1'b1;
            ram_waddr    = node_ff;
            ram_wdata    = {crow_val, free_head_ff, crow_prev};
            free_head_in = node_ff;
            count_in     = count_ff - CW'(1);
            if (count_ff == CW'(1)) begin
               cursor_in = '0;
            end
            state_in = ST_RESP;
         end

         ST_ROT_DIV: begin
            if (div_done) begin
               left_in  = div_rem;
               state_in = ST_ROT_WALK;
            end
         end

         ST_ROT_WALK: begin
            // Advance one link per cycle until the reduced step count is used up
            if (left_ff == '0) begin
               res_data_in = ext_val(walk_val);
               state_in    = ST_RESP;
            end else begin
               cursor_in = walk_next;
               ram_raddr = walk_next;
               left_in   = left_ff - CW'(1);
               first_in  = 1'b0;
            end
         end

         ST_RESP: begin
            // Hand the response to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_count_in  = count_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         count_ff     <= '0;
         free_head_ff <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         count_ff     <= count_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      steps_ff      <= steps_in;
      node_ff       <= node_in;
      crow_ff       <= crow_in;
      prow_ff       <= prow_in;
      nrow_ff       <= nrow_in;
      left_ff       <= left_in;
      first_ff      <= first_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   clwc_ram #(
      .WIDTH (RW),
      .DEPTH (CAPACITY)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   clwc_mod #(
      .DIVIDEND_BITS (clwc_pkg::MAG_BITS),
      .DIVISOR_BITS  (CW)
   ) u_step_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (step_mag),
      .divisor   (count_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above pool size");

   a_fill_covers: assert property (@(posedge clock) disable iff (reset)
      fresh_ff >= count_ff)
      else $error("more elements than nodes ever handed out");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff != ST_IDLE) && (state_ff != ST_RESP))
      else $error("node RAM written outside a command");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("response raised outside the response state");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_DISPATCH)
      else $error("accepted request not dispatched");

endmodule

// ===== tb/sv/tb_circular_list_with_cursor_top.sv =====
module tb_circular_list_with_cursor_top;
   timeunit 1ns;
   timeprecision 1ps;

   import clwc_pkg::*;

   localparam int POOL_SIZE    = CAPACITY_DEFAULT;
   localparam int COUNT_BITS   = $clog2(POOL_SIZE + 1);
   localparam int QUIET_LIMIT  = 4000;
   localparam int SETTLE_TICKS = 400;

   typedef struct {
      logic signed [DATA_BITS-1:0] data;
      logic [COUNT_BITS-1:0]       count;
      logic [STAT_BITS-1:0]        status;
   } ring_reply_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [CMD_BITS-1:0]         req_cmd;
   logic signed [DATA_BITS-1:0] req_value;
   logic signed [STEP_BITS-1:0] req_rotate_steps;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic signed [DATA_BITS-1:0] rsp_data;
   logic [COUNT_BITS-1:0]       rsp_count;
   logic [STAT_BITS-1:0]        rsp_status;

   // Shadow copy of the ring held in the node pool
   logic [DATA_BITS-1:0] node_value [POOL_SIZE];
   int                   node_next  [POOL_SIZE];
   int                   node_prev  [POOL_SIZE];
   int                   free_next  [POOL_SIZE];
   int                   free_head;
   int                   cursor_node;
   int                   ring_len;

   ring_reply_type ring_replies_due[$];

   bit no_idle;
   int error_count;
   int requests_sent;
   int replies_seen;
   int full_replies;
   int empty_replies;
   int quiet_cycles;

   circular_list_with_cursor_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .req_rotate_steps (req_rotate_steps),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .rsp_count        (rsp_count),
      .rsp_status       (rsp_status)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Put the shadow ring into its post-reset state
   function automatic void clear_ring();
      for (int i = 0; i < POOL_SIZE; i++) begin
         node_value[i] = '0;
         node_next[i]  = 0;
         node_prev[i]  = 0;
         free_next[i]  = (i + 1) % POOL_SIZE;
      end
      free_head   = 0;
      cursor_node = 0;
      ring_len    = 0;
   endfunction

   // Apply one command to the shadow ring and return the reply it should give
   function automatic ring_reply_type apply_to_ring(input logic [CMD_BITS-1:0] cmd,
                                                    input logic signed [DATA_BITS-1:0] value,
                                                    input logic signed [STEP_BITS-1:0] steps);
      ring_reply_type reply;
      int          node;
      int          succ;
      int          pred;
      int unsigned raw;
      int unsigned mag;
      int unsigned walk;
      bit          took_value;
      bit          backward;
      reply      = '{default: '0};
      reply.status = STATUS_OK;
      took_value = 1'b0;
      case (cmd)
         CMD_INSERT: begin
            if (ring_len >= POOL_SIZE) begin
               reply.status = STATUS_FULL;
            end else begin
               node      = free_head;
               free_head = free_next[node];
               node_value[node] = value;
               if (ring_len == 0) begin
                  node_next[node] = node;
                  node_prev[node] = node;
               end else begin
                  succ = node_next[cursor_node];
                  node_next[node]        = succ;
                  node_prev[node]        = cursor_node;
                  node_next[cursor_node] = node;
                  node_prev[succ]        = node;
               end
               cursor_node = node;
               ring_len++;
            end
         end
         CMD_DELETE: begin
            if (ring_len == 0) begin
               reply.status = STATUS_EMPTY;
               took_value   = 1'b1;
            end else begin
               node       = cursor_node;
               reply.data = node_value[node];
               took_value = 1'b1;
               if (ring_len == 1) begin
                  cursor_node = 0;
               end else begin
                  pred = node_prev[node];
                  succ = node_next[node];
                  node_next[pred] = succ;
                  node_prev[succ] = pred;
                  cursor_node     = succ;
               end
               free_next[node] = free_head;
               free_head       = node;
               ring_len--;
            end
         end
         CMD_ROTATE: begin
            if (ring_len != 0) begin
               raw      = {16'd0, steps};
               backward = steps[STEP_BITS-1];
               mag      = backward ? (32'h10000 - raw) : raw;
               walk     = mag % ring_len;
               for (int unsigned i = 0; i < walk; i++)
                  cursor_node = backward ? node_prev[cursor_node] : node_next[cursor_node];
            end
         end
         default: begin
         end
      endcase
      if (!took_value)
         reply.data = (ring_len == 0) ? '0 : node_value[cursor_node];
      reply.count = COUNT_BITS'(ring_len);
      return reply;
   endfunction

   // Present one request, hold it until taken, then log the reply it owes
   task automatic send_request(input logic [CMD_BITS-1:0] cmd,
                               input logic signed [DATA_BITS-1:0] value,
                               input logic signed [STEP_BITS-1:0] steps);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_value        <= value;
      req_rotate_steps <= steps;
      do @(posedge clock); while (req_ready !== 1'b1);
      ring_replies_due.push_back(apply_to_ring(cmd, value, steps));
      requests_sent++;
   endtask

   // Step counts: mostly short walks, some long ones and the extremes
   function automatic logic signed [STEP_BITS-1:0] random_steps();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2, 3:    return STEP_BITS'($urandom);
         4:       return STEP_BITS'($urandom_range(0, 600) - 300);
         default: return STEP_BITS'($urandom_range(0, 8) - 4);
      endcase
   endfunction

   function automatic logic [CMD_BITS-1:0] pick_command(input int ins_w, input int del_w,
                                                        input int rot_w);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < ins_w)
         return CMD_INSERT;
      else if (roll < ins_w + del_w)
         return CMD_DELETE;
      else if (roll < ins_w + del_w + rot_w)
         return CMD_ROTATE;
      return CMD_QUERY;
   endfunction

   // Commands on an empty ring
   task automatic test_empty_list();
      send_request(CMD_DELETE, 32'sh1234_5678, 16'sd0);
      send_request(CMD_ROTATE, 32'sd0, 16'sd0);
      send_request(CMD_ROTATE, 32'sd0, -16'sd1);
      send_request(CMD_ROTATE, 32'sd0, 16'sh7FFF);
      send_request(CMD_QUERY, -32'sd1, 16'sh8000);
   endtask

   // A ring of one node, with extreme values and step counts
   task automatic test_single_node();
      send_request(CMD_INSERT, 32'sh7FFF_FFFF, 16'sd0);
      send_request(CMD_QUERY, 32'sd0, 16'sd0);
      send_request(CMD_ROTATE, 32'sd0, 16'sh8000);
      send_request(CMD_DELETE, 32'sd0, 16'sd0);
      send_request(CMD_QUERY, 32'sd0, 16'sd0);
      send_request(CMD_INSERT, 32'sh8000_0000, 16'sh7FFF);
      send_request(CMD_ROTATE, 32'sd0, 16'sd5);
      send_request(CMD_DELETE, 32'sd0, 16'sd0);
   endtask

   // A short ring: walk both ways, wrap, then take it apart past empty
   task automatic test_small_ring();
      send_request(CMD_INSERT, 32'sd0, 16'sd0);
      send_request(CMD_INSERT, -32'sd1, 16'sd0);
      send_request(CMD_INSERT, 32'sh5555_5555, 16'sd0);
      send_request(CMD_ROTATE, 32'sd0, 16'sd1);
      send_request(CMD_ROTATE, 32'sd0, -16'sd1);
      send_request(CMD_ROTATE, 32'sd0, 16'sh7FFF);
      send_request(CMD_ROTATE, 32'sd0, 16'sh8000);
      send_request(CMD_ROTATE, 32'sd0, 16'sd0);
      send_request(CMD_DELETE, 32'sd0, 16'sd0);
      send_request(CMD_QUERY, 32'sd0, 16'sd0);
      send_request(CMD_DELETE, 32'sd0, 16'sd0);
      send_request(CMD_DELETE, 32'sd0, 16'sd0);
      send_request(CMD_DELETE, 32'sd0, 16'sd0);
   endtask

   // Free mix of all commands on a ring that stays fairly short
   task automatic test_random_mix(input int n);
      repeat (n)
         send_request(pick_command(38, 30, 20), $urandom, random_steps());
   endtask

   // Grow the ring until the pool is exhausted, then push inserts against it
   task automatic test_fill_pool();
      while (ring_len < POOL_SIZE)
         send_request(pick_command(80, 8, 6), $urandom, random_steps());
      repeat (12)
         send_request(pick_command(70, 0, 15), $urandom, random_steps());
   endtask

   // Long walks around a ring that starts out filling the whole pool
   task automatic test_full_ring_walks();
      repeat (80)
         send_request(pick_command(5, 5, 70), $urandom, random_steps());
   endtask

   // Shrink the ring to nothing and keep deleting
   task automatic test_drain();
      while (ring_len > 0)
         send_request(pick_command(6, 75, 12), $urandom, random_steps());
      repeat (3)
         send_request(CMD_DELETE, $urandom, random_steps());
   endtask

   // Back-to-back traffic with no gaps on either side
   task automatic test_burst();
      no_idle = 1'b1;
      test_random_mix(300);
      no_idle = 1'b0;
   endtask

   // Reply side: hold off a random number of cycles per reply
   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 15);
         @(negedge clock);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && reset === 1'b0));
      end
   end

   // Compare each reply with the oldest one owed
   always @(posedge clock) begin : check_replies
      ring_reply_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         replies_seen++;
         if (ring_replies_due.size() == 0) begin
            error_count++;
            $display("%0t: reply with none owed: data %h count %0d status %0d",
                     $time, rsp_data, rsp_count, rsp_status);
         end else begin
            want = ring_replies_due.pop_front();
            if (want.status == STATUS_FULL)
               full_replies++;
            if (want.status == STATUS_EMPTY)
               empty_replies++;
            if (rsp_data !== want.data) begin
               error_count++;
               $display("%0t: data expected %h, got %h", $time, want.data, rsp_data);
            end
            if (rsp_count !== want.count) begin
               error_count++;
               $display("%0t: count expected %0d, got %0d", $time, want.count, rsp_count);
            end
            if (rsp_status !== want.status) begin
               error_count++;
               $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_status);
            end
         end
      end
   end

   // Abort if neither channel moves for too long
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_ready === 1'b1) ||
          (rsp_valid === 1'b1 && rsp_ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d replies outstanding",
                  $time, quiet_cycles, ring_replies_due.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_cmd          = CMD_QUERY;
      req_value        = '0;
      req_rotate_steps = '0;
      no_idle          = 1'b0;
      requests_sent    = 0;
      clear_ring();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_single_node();
      test_small_ring();
      test_random_mix(450);
      test_fill_pool();
      test_full_ring_walks();
      test_drain();
      test_burst();

      @(negedge clock);
      req_valid <= 1'b0;
      while (ring_replies_due.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);

      $display("covered %0d requests and %0d replies: empty and single-node rings, a full pool,",
               requests_sent, replies_seen);
      $display("long walks both ways; %0d pool-full and %0d empty-list rejections",
               full_replies, empty_replies);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
